// File: rtl/cbq_pkg.sv
// Shared constants, codes and types of the cascaded biquad filter.
// No dependencies; imported by cbq_mac, cascaded_biquad_filter and cbq_checker.
package cbq_pkg;

  localparam int MAX_SECTIONS = 10;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int FRAC_BITS    = COEF_BITS - 4;

  // exact sum of five products
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;

  localparam int COEF_SLOTS = 5;
  localparam int HIST_SLOTS = 4;
  localparam int COEF_DEPTH = MAX_SECTIONS * COEF_SLOTS;
  localparam int HIST_DEPTH = MAX_SECTIONS * HIST_SLOTS;
  localparam int COEF_ADDR_BITS = $clog2(COEF_DEPTH);
  localparam int HIST_SLOT_BITS = 2;
  localparam int SEC_BITS = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int HIST_ADDR_BITS = SEC_BITS + HIST_SLOT_BITS;

  // field widths fixed by the interface
  localparam int OPCODE_BITS  = 2;
  localparam int SECTION_BITS = 4;
  localparam int SLOT_BITS    = 3;
  localparam int COUNT_BITS   = 4;

  localparam logic [OPCODE_BITS-1:0] OP_FILTER = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_COEF   = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SECTION_COUNT = 2'd1;

  // control word from the sequencer to the shared MAC
  typedef struct packed {
    logic mul_en;    // register coef * data
    logic acc_load;  // start a new sum with the product
    logic acc_en;    // add the product to the running sum
    logic acc_sub;   // product enters negated
  } mac_ctl_t;

endpackage

// File: rtl/cbq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cbq_mac.sv
// Shared multiply-accumulate unit with round-to-nearest and saturation.
// Depends on cbq_pkg.
module cbq_mac import cbq_pkg::*; (
  input  logic                          clk,
  input  mac_ctl_t                      ctl,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0] data,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          clip
);

  localparam int RND_BITS = ACC_BITS + 1;
  localparam logic signed [RND_BITS-1:0] HALF = RND_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_BITS-1:0] SMAX = (RND_BITS'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [RND_BITS-1:0] SMIN = -SMAX - 1;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  term;
  logic signed [RND_BITS-1:0]  rnd;
  logic signed [RND_BITS-1:0]  shf;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= coef * data;
    end
    if (ctl.acc_load) begin
      acc <= term;
    end else if (ctl.acc_en) begin
      acc <= acc + term;
    end
  end

  always_comb begin
    term = ctl.acc_sub ? -ACC_BITS'(prod) : ACC_BITS'(prod);
    rnd  = RND_BITS'(acc) + HALF;
    shf  = rnd >>> FRAC_BITS;  // arithmetic shift is floor
    clip = 1'b1;
    if (shf > SMAX) begin
      y = SMAX[SAMPLE_BITS-1:0];
    end else if (shf < SMIN) begin
      y = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y    = shf[SAMPLE_BITS-1:0];
      clip = 1'b0;
    end
  end

endmodule

// File: rtl/cascaded_biquad_filter.sv
// Cascaded direct-form-I biquad filter: sequencer, coefficient and history
// stores, shared MAC. Depends on cbq_pkg, cbq_ram and cbq_mac.
//
// Input channel (in_valid / in_stall): one transaction per item. opcode
// selects filter sample, coefficient write or history clear; unused
// opcodes are dropped. Only filter items produce an output transaction.
// Output channel (out_valid / out_stall): sample_out, saturated and
// block_end_out, held in an output register until taken.
// Config port (cfg_valid / cfg_ready, always ready): index 0 bypass,
// index 1 section_count; other indexes are ignored. Write only when idle.
// Coefficient writes, clears and dropped items do not stall the input.
// A filter item runs, for each section in use, coefficient read-ahead,
// five products, last add and round/saturate/history write, then loads the
// output register; the next item is accepted only after that load. In
// bypass the sections are skipped. in_stall stays high from a filter
// accept until its result moves to the output register.
// Reset: config to defaults; coefficients and history invalidated at once by
// valid bits (unwritten entries read as zero), no memory sweep.
// Stalls: the output register holds; a finished sample waits in the done
// state behind it, and the input stays stalled meanwhile.
module cascaded_biquad_filter import cbq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // input item
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OPCODE_BITS-1:0]        opcode,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_end,
  input  logic [SECTION_BITS-1:0]       coef_section,
  input  logic [SLOT_BITS-1:0]          coef_slot,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  // result item
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated,
  output logic                          block_end_out,
  // config writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // phase within one section
  localparam logic [2:0] PH_RD_B0  = 3'd0;  // read b0
  localparam logic [2:0] PH_MUL_B0 = 3'd1;  // b0*x, read b1 / x1
  localparam logic [2:0] PH_MUL_B1 = 3'd2;  // b1*x1, sum starts
  localparam logic [2:0] PH_MUL_B2 = 3'd3;  // b2*x2, write x1 <= x
  localparam logic [2:0] PH_MUL_A1 = 3'd4;  // a1*y1, write x2 <= x1
  localparam logic [2:0] PH_MUL_A2 = 3'd5;  // a2*y2
  localparam logic [2:0] PH_ACC_A2 = 3'd6;  // last add, write y2 <= y1
  localparam logic [2:0] PH_OUT    = 3'd7;  // round, write y1 <= y

  localparam logic [HIST_SLOT_BITS-1:0] H_X1 = 2'd0;
  localparam logic [HIST_SLOT_BITS-1:0] H_X2 = 2'd1;
  localparam logic [HIST_SLOT_BITS-1:0] H_Y1 = 2'd2;
  localparam logic [HIST_SLOT_BITS-1:0] H_Y2 = 2'd3;

  localparam int CNT_W = COUNT_BITS + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SECTIONS);

  logic [1:0]            state;
  logic [2:0]            phase;
  logic [SEC_BITS-1:0]   sec;
  logic [SEC_BITS-1:0]   last_sec;
  logic                  bypass;
  logic [COUNT_BITS-1:0] section_count;

  logic [COEF_DEPTH-1:0]   coef_vld;
  logic [MAX_SECTIONS-1:0] hist_vld;
  logic                    coef_ok;

  // working payload
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] h0r;
  logic signed [SAMPLE_BITS-1:0] h2r;
  logic                          sat;
  logic                          be_r;

  logic in_acc;
  logic out_load;

  // coefficient store
  logic                      coef_we;
  logic [COEF_ADDR_BITS-1:0] coef_waddr;
  logic [COEF_ADDR_BITS-1:0] coef_raddr;
  logic [SLOT_BITS-1:0]      coef_rslot;
  logic [COEF_BITS-1:0]      coef_rdata;

  // history store
  logic                      hist_we;
  logic [HIST_SLOT_BITS-1:0] hist_wslot;
  logic [SAMPLE_BITS-1:0]    hist_wdata;
  logic [HIST_SLOT_BITS-1:0] hist_rslot;
  logic [SAMPLE_BITS-1:0]    hist_rdata;
  logic signed [SAMPLE_BITS-1:0] hist_q;

  // MAC
  mac_ctl_t                      mac_ctl;
  logic signed [COEF_BITS-1:0]   mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_data;
  logic signed [SAMPLE_BITS-1:0] mac_y;
  logic                          mac_clip;
  logic                          use_x;

  logic [CNT_W-1:0] cnt_lim;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // section count clamped to 1..MAX_SECTIONS
  always_comb begin
    cnt_lim = {1'b0, section_count};
    if (cnt_lim == '0) begin
      cnt_lim = CNT_W'(1);
    end else if (cnt_lim > MAX_CNT) begin
      cnt_lim = MAX_CNT;
    end
  end

  // coefficient address = section * 5 + slot
  assign coef_we = in_acc && (opcode == OP_COEF)
                   && ({1'b0, coef_section} < (SECTION_BITS + 1)'(MAX_SECTIONS))
                   && (coef_slot < SLOT_BITS'(COEF_SLOTS));
  assign coef_waddr = COEF_ADDR_BITS'({coef_section, 2'b00})
                      + COEF_ADDR_BITS'(coef_section) + COEF_ADDR_BITS'(coef_slot);
  assign coef_raddr = COEF_ADDR_BITS'({sec, 2'b00}) + COEF_ADDR_BITS'(sec)
                      + COEF_ADDR_BITS'(coef_rslot);

  // unwritten history of this section reads as zero
  assign hist_q = hist_vld[sec] ? $signed(hist_rdata) : '0;

  // per-phase control
  always_comb begin
    coef_rslot = '0;
    hist_rslot = H_X1;
    hist_we    = 1'b0;
    hist_wslot = H_X1;
    hist_wdata = x;
    mac_ctl    = '0;
    use_x      = 1'b0;
    case (phase)
      PH_RD_B0: begin
        coef_rslot = 3'd0;
      end
      PH_MUL_B0: begin
        coef_rslot     = 3'd1;
        hist_rslot     = H_X1;
        mac_ctl.mul_en = 1'b1;
        use_x          = 1'b1;
      end
      PH_MUL_B1: begin
        coef_rslot       = 3'd2;
        hist_rslot       = H_X2;
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
      end
      PH_MUL_B2: begin
        coef_rslot     = 3'd3;
        hist_rslot     = H_Y1;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        hist_we        = 1'b1;
        hist_wslot     = H_X1;
        hist_wdata     = x;
      end
      PH_MUL_A1: begin
        coef_rslot     = 3'd4;
        hist_rslot     = H_Y2;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        hist_we        = 1'b1;
        hist_wslot     = H_X2;
        hist_wdata     = h0r;
      end
      PH_MUL_A2: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_en  = 1'b1;
        mac_ctl.acc_sub = 1'b1;
      end
      PH_ACC_A2: begin
        mac_ctl.acc_en  = 1'b1;
        mac_ctl.acc_sub = 1'b1;
        hist_we         = 1'b1;
        hist_wslot      = H_Y2;
        hist_wdata      = h2r;
      end
      PH_OUT: begin
        hist_we    = 1'b1;
        hist_wslot = H_Y1;
        hist_wdata = mac_y;
      end
      default: begin
      end
    endcase
    if (state != ST_RUN) begin
      hist_we = 1'b0;
      mac_ctl = '0;
    end
  end

  assign mac_coef = coef_ok ? $signed(coef_rdata) : '0;
  assign mac_data = use_x ? x : hist_q;

  cbq_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  cbq_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr ({sec, hist_wslot}),
    .wdata (hist_wdata),
    .raddr ({sec, hist_rslot}),
    .rdata (hist_rdata)
  );

  cbq_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (mac_coef),
    .data (mac_data),
    .y    (mac_y),
    .clip (mac_clip)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_RD_B0;
      out_valid     <= 1'b0;
      bypass        <= 1'b0;
      section_count <= COUNT_BITS'(1);
      coef_vld      <= '0;
      hist_vld      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BYPASS:        bypass        <= cfg_data[0];
          REG_SECTION_COUNT: section_count <= cfg_data;
          default: begin
          end
        endcase
      end

      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc && opcode == OP_CLEAR) begin
            hist_vld <= '0;
          end
          if (in_acc && opcode == OP_FILTER) begin
            phase <= PH_RD_B0;
            state <= bypass ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          phase <= phase + 3'd1;
          if (phase == PH_OUT) begin
            hist_vld[sec] <= 1'b1;
            if (sec == last_sec) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    coef_ok <= coef_vld[coef_raddr];
    if (in_acc && opcode == OP_FILTER) begin
      x        <= sample_in;
      sat      <= 1'b0;
      be_r     <= block_end;
      sec      <= '0;
      last_sec <= SEC_BITS'(cnt_lim - CNT_W'(1));
    end
    if (state == ST_RUN) begin
      if (phase == PH_MUL_B1) begin
        h0r <= hist_q;
      end
      if (phase == PH_MUL_A1) begin
        h2r <= hist_q;
      end
      if (phase == PH_OUT) begin
        x   <= mac_y;
        sat <= sat | mac_clip;
        sec <= sec + SEC_BITS'(1);
      end
    end
    if (out_load) begin
      sample_out    <= x;
      saturated     <= sat;
      block_end_out <= be_r;
    end
  end

endmodule

// File: rtl/cbq_checker.sv
// Port-level checks for the cascaded biquad filter, bound to the top level.
// Depends on cbq_pkg and cascaded_biquad_filter.
module cbq_checker import cbq_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [OPCODE_BITS-1:0]        opcode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          saturated,
  input logic                          block_end_out
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(sample_out) && $stable(saturated) && $stable(block_end_out)))
    else $error("stalled result changed");

  // a filter transaction makes the block busy
  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode == OP_FILTER) |=> in_stall)
    else $error("not busy after filter transaction");

  // a new result only comes out of a busy period
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a filter transaction in progress");

endmodule

bind cascaded_biquad_filter cbq_checker u_cbq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .opcode        (opcode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .sample_out    (sample_out),
  .saturated     (saturated),
  .block_end_out (block_end_out)
);
